[design/srgbxy_pkg.sv]
// ----------------------------------------------------------------------------
// srgbxy_pkg
// shared constants, types and the srgb linearization table
// ----------------------------------------------------------------------------
package srgbxy_pkg;

   localparam int DefFracBits = 16;
   localparam int ChanW       = 8;
   localparam int LinW        = 16;
   localparam int OutW        = 16;

   // matrix entries in ten-thousandths
   localparam int CoefXR = 4124;
   localparam int CoefXG = 3576;
   localparam int CoefXB = 1805;
   localparam int CoefYR = 2126;
   localparam int CoefYG = 7152;
   localparam int CoefYB = 722;
   localparam int CoefZR = 193;
   localparam int CoefZG = 1192;
   localparam int CoefZB = 9505;

   typedef logic [LinW-1:0] lin_rom_type [256];

   typedef struct packed {
      logic valid;
      logic zero;
   } ctl_type;

   // round(65535 * inverse gamma(v/255)), ties upward
   function automatic lin_rom_type build_lin_rom();
      lin_rom_type rom;
      longint      lin;
      real         t;
      real         p;
      for (int v = 0; v < 256; v++) begin
         if (100000 * v > 1031475) begin
            t = (40.0 * v + 561.0) / 10761.0;
            p = 65535.0 * (t ** 2.4);
            rom[v] = LinW'($rtoi(p + 0.5));
         end else begin
            lin = (longint'(13107000) * v + 329460) / 658920;
            rom[v] = LinW'(lin);
         end
      end
      return rom;
   endfunction

   localparam lin_rom_type LinRom = build_lin_rom();

   // round(c * 2^frac), c given in ten-thousandths
   function automatic longint coef_q(input longint tt, input int frac);
      return ((tt << (frac + 1)) + 10000) / 20000;
   endfunction

endpackage

[design/srgb_to_cie_xy.sv]
// ----------------------------------------------------------------------------
// srgb_to_cie_xy
// 8-bit srgb pixel to cie 1931 xy chromaticity, fully pipelined
// ----------------------------------------------------------------------------
// structure: 4 front stages, then 16 divider cells between start and rsp_valid
// throughput: one pixel per cycle; busy is always low, the divider chain
//    retires one quotient bit per cell so every stage is free each cycle
// reset: clears the valid bits of every stage, results in flight are dropped
// the receiver cannot stall; rsp_valid marks each transfer for one cycle
module srgb_to_cie_xy #(
   parameter int FRAC_BITS = srgbxy_pkg::DefFracBits
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [srgbxy_pkg::ChanW-1:0]    req_red,
   input  logic [srgbxy_pkg::ChanW-1:0]    req_green,
   input  logic [srgbxy_pkg::ChanW-1:0]    req_blue,
   output logic                            rsp_valid,
   output logic [srgbxy_pkg::OutW-1:0]     rsp_chroma_x,
   output logic [srgbxy_pkg::OutW-1:0]     rsp_chroma_y
);
   import srgbxy_pkg::*;

   // sum of x+y+z fits in lin width plus coefficient width plus two
   localparam int SW = LinW + FRAC_BITS + 2;
   // numerator is the x or y sum times 65535
   localparam int NW = SW + OutW;

   // chain links: index 0 is the front end output, index OutW the last cell
   ctl_type         ctl   [OutW+1];
   logic [NW-1:0]   rem_x [OutW+1];
   logic [NW-1:0]   rem_y [OutW+1];
   logic [SW-1:0]   dvs   [OutW+1];
   logic [OutW-1:0] quo_x [OutW+1];
   logic [OutW-1:0] quo_y [OutW+1];

   // no backpressure anywhere in the pipe
   assign busy = 1'b0;

   srgbxy_mix #(
      .FRAC_BITS (FRAC_BITS),
      .SW        (SW),
      .NW        (NW)
   ) u_mix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start),
      .red       (req_red),
      .green     (req_green),
      .blue      (req_blue),
      .ctl_out   (ctl[0]),
      .num_x_out (rem_x[0]),
      .num_y_out (rem_y[0]),
      .sum_out   (dvs[0])
   );

   assign quo_x[0] = '0;
   assign quo_y[0] = '0;

   // msb first: cell k decides quotient bit OutW-1-k
   for (genvar k = 0; k < OutW; k++) begin : g_cell
      srgbxy_div_cell #(
         .SW    (SW),
         .NW    (NW),
         .SHIFT (OutW - 1 - k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl_in    (ctl[k]),
         .rem_x_in  (rem_x[k]),
         .rem_y_in  (rem_y[k]),
         .div_in    (dvs[k]),
         .quo_x_in  (quo_x[k]),
         .quo_y_in  (quo_y[k]),
         .ctl_out   (ctl[k+1]),
         .rem_x_out (rem_x[k+1]),
         .rem_y_out (rem_y[k+1]),
         .div_out   (dvs[k+1]),
         .quo_x_out (quo_x[k+1]),
         .quo_y_out (quo_y[k+1])
      );
   end

   // black pixel leaves the quotients at zero inside the cells
   assign rsp_valid    = ctl[OutW].valid;
   assign rsp_chroma_x = quo_x[OutW];
   assign rsp_chroma_y = quo_y[OutW];

endmodule

[design/srgbxy_mix.sv]
// ----------------------------------------------------------------------------
// srgbxy_mix
// linearization, color matrix and sum; feeds the divider chain
// ----------------------------------------------------------------------------
module srgbxy_mix #(
   parameter int FRAC_BITS = srgbxy_pkg::DefFracBits,
   parameter int SW        = srgbxy_pkg::LinW + FRAC_BITS + 2,
   parameter int NW        = SW + srgbxy_pkg::OutW
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  logic [srgbxy_pkg::ChanW-1:0]    red,
   input  logic [srgbxy_pkg::ChanW-1:0]    green,
   input  logic [srgbxy_pkg::ChanW-1:0]    blue,
   output srgbxy_pkg::ctl_type             ctl_out,
   output logic [NW-1:0]                   num_x_out,
   output logic [NW-1:0]                   num_y_out,
   output logic [SW-1:0]                   sum_out
);
   import srgbxy_pkg::*;

   localparam int CW = FRAC_BITS;
   localparam int PW = LinW + CW;

   localparam logic [CW-1:0] KXR = CW'(coef_q(CoefXR, FRAC_BITS));
   localparam logic [CW-1:0] KXG = CW'(coef_q(CoefXG, FRAC_BITS));
   localparam logic [CW-1:0] KXB = CW'(coef_q(CoefXB, FRAC_BITS));
   localparam logic [CW-1:0] KYR = CW'(coef_q(CoefYR, FRAC_BITS));
   localparam logic [CW-1:0] KYG = CW'(coef_q(CoefYG, FRAC_BITS));
   localparam logic [CW-1:0] KYB = CW'(coef_q(CoefYB, FRAC_BITS));
   localparam logic [CW-1:0] KZR = CW'(coef_q(CoefZR, FRAC_BITS));
   localparam logic [CW-1:0] KZG = CW'(coef_q(CoefZG, FRAC_BITS));
   localparam logic [CW-1:0] KZB = CW'(coef_q(CoefZB, FRAC_BITS));

   logic [3:0]      valid_ff;
   logic [LinW-1:0] lr_ff, lg_ff, lb_ff;
   logic [PW-1:0]   pxr_ff, pxg_ff, pxb_ff, pyr_ff, pyg_ff, pyb_ff;
   logic [PW-1:0]   pzr_ff, pzg_ff, pzb_ff;
   logic [SW-1:0]   cx_ff, cy_ff, cz_ff;
   logic [SW-1:0]   sum_ff;
   logic [NW-1:0]   nx_ff, ny_ff;
   logic [SW-1:0]   sum_in;

   assign sum_in = cx_ff + cy_ff + cz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
      lr_ff  <= LinRom[red];
      lg_ff  <= LinRom[green];
      lb_ff  <= LinRom[blue];
      pxr_ff <= PW'(lr_ff * KXR);
      pxg_ff <= PW'(lg_ff * KXG);
      pxb_ff <= PW'(lb_ff * KXB);
      pyr_ff <= PW'(lr_ff * KYR);
      pyg_ff <= PW'(lg_ff * KYG);
      pyb_ff <= PW'(lb_ff * KYB);
      pzr_ff <= PW'(lr_ff * KZR);
      pzg_ff <= PW'(lg_ff * KZG);
      pzb_ff <= PW'(lb_ff * KZB);
      cx_ff  <= SW'(pxr_ff) + SW'(pxg_ff) + SW'(pxb_ff);
      cy_ff  <= SW'(pyr_ff) + SW'(pyg_ff) + SW'(pyb_ff);
      cz_ff  <= SW'(pzr_ff) + SW'(pzg_ff) + SW'(pzb_ff);
      sum_ff <= sum_in;
      // times 65535 as shift and subtract
      nx_ff  <= (NW'(cx_ff) << OutW) - NW'(cx_ff);
      ny_ff  <= (NW'(cy_ff) << OutW) - NW'(cy_ff);
   end

   assign ctl_out.valid = valid_ff[3];
   assign ctl_out.zero  = (sum_ff == '0);
   assign num_x_out     = nx_ff;
   assign num_y_out     = ny_ff;
   assign sum_out       = sum_ff;

endmodule

[design/srgbxy_div_cell.sv]
// ----------------------------------------------------------------------------
// srgbxy_div_cell
// one restoring-division step for both quotients
// ----------------------------------------------------------------------------
module srgbxy_div_cell #(
   parameter int SW    = 34,
   parameter int NW    = 50,
   parameter int SHIFT = 0
) (
   input  logic                              clock,
   input  logic                              reset,
   input  srgbxy_pkg::ctl_type               ctl_in,
   input  logic [NW-1:0]                     rem_x_in,
   input  logic [NW-1:0]                     rem_y_in,
   input  logic [SW-1:0]                     div_in,
   input  logic [srgbxy_pkg::OutW-1:0]       quo_x_in,
   input  logic [srgbxy_pkg::OutW-1:0]       quo_y_in,
   output srgbxy_pkg::ctl_type               ctl_out,
   output logic [NW-1:0]                     rem_x_out,
   output logic [NW-1:0]                     rem_y_out,
   output logic [SW-1:0]                     div_out,
   output logic [srgbxy_pkg::OutW-1:0]       quo_x_out,
   output logic [srgbxy_pkg::OutW-1:0]       quo_y_out
);
   import srgbxy_pkg::*;

   ctl_type         ctl_ff;
   logic [NW-1:0]   rem_x_ff, rem_y_ff;
   logic [SW-1:0]   div_ff;
   logic [OutW-1:0] quo_x_ff, quo_y_ff;
   logic [NW-1:0]   dsh;
   logic            ge_x, ge_y;
   logic [OutW-1:0] bit_mask;

   assign dsh      = NW'(div_in) << SHIFT;
   assign ge_x     = (rem_x_in >= dsh);
   assign ge_y     = (rem_y_in >= dsh);
   assign bit_mask = OutW'(1) << SHIFT;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
      rem_x_ff <= ge_x ? rem_x_in - dsh : rem_x_in;
      rem_y_ff <= ge_y ? rem_y_in - dsh : rem_y_in;
      div_ff   <= div_in;
      quo_x_ff <= (ge_x && !ctl_in.zero) ? (quo_x_in | bit_mask) : quo_x_in;
      quo_y_ff <= (ge_y && !ctl_in.zero) ? (quo_y_in | bit_mask) : quo_y_in;
   end

   assign ctl_out   = ctl_ff;
   assign rem_x_out = rem_x_ff;
   assign rem_y_out = rem_y_ff;
   assign div_out   = div_ff;
   assign quo_x_out = quo_x_ff;
   assign quo_y_out = quo_y_ff;

endmodule

[sim/srgb_to_cie_xy_tb.sv]
// ----------------------------------------------------------------------------
// srgb_to_cie_xy_tb
// drives pixels through the chromaticity pipeline and checks every result
// against an exact integer prediction of the linearization and division
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module srgb_to_cie_xy_tb;

   import srgbxy_pkg::*;

   localparam int NumRandom  = 880;
   localparam int DrainWait  = 40;
   localparam int MaxReports = 10;

   typedef struct {
      logic [ChanW-1:0] red;
      logic [ChanW-1:0] green;
      logic [ChanW-1:0] blue;
   } pixel_type;

   typedef struct {
      logic [OutW-1:0] chroma_x;
      logic [OutW-1:0] chroma_y;
   } chroma_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   logic [ChanW-1:0] req_red   = '0;
   logic [ChanW-1:0] req_green = '0;
   logic [ChanW-1:0] req_blue  = '0;
   logic             rsp_valid;
   logic [OutW-1:0]  rsp_chroma_x;
   logic [OutW-1:0]  rsp_chroma_y;

   pixel_type        pixel_q[$];
   chroma_type       chroma_q[$];
   logic [LinW-1:0]  gamma_lut[256];
   int               accepted_cnt = 0;
   int               mismatch_cnt = 0;

   srgb_to_cie_xy i_dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_red      (req_red),
      .req_green    (req_green),
      .req_blue     (req_blue),
      .rsp_valid    (rsp_valid),
      .rsp_chroma_x (rsp_chroma_x),
      .rsp_chroma_y (rsp_chroma_y)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // exact inverse gamma table, rounded to nearest with ties upward
   // power segment: largest k with (2k-1)^5 * 10761^12 <= 32 * 65535^5 * (40v+561)^12
   function automatic void fill_gamma_lut();
      bit [299:0] den_pow;
      bit [299:0] bound;
      bit [299:0] lhs;
      int         lo;
      int         hi;
      int         mid;
      den_pow = 300'd1;
      repeat (12) den_pow = den_pow * 300'd10761;
      for (int v = 0; v < 256; v++) begin
         if (100000 * v > 1031475) begin
            bound = 300'd32;
            repeat (5) bound = bound * 300'd65535;
            repeat (12) bound = bound * 300'(40 * v + 561);
            lo = 0;
            hi = 65535;
            while (lo < hi) begin
               mid = (lo + hi + 1) / 2;
               lhs = den_pow;
               repeat (5) lhs = lhs * 300'(2 * mid - 1);
               if (lhs <= bound) lo = mid;
               else hi = mid - 1;
            end
            gamma_lut[v] = LinW'(lo);
         end else begin
            // linear segment near black
            gamma_lut[v] = LinW'((longint'(13107000) * v + 329460) / 658920);
         end
      end
   endfunction

   // matrix entry in q0.16, given in ten-thousandths
   function automatic longint unsigned to_q16(input longint unsigned tt);
      return ((tt << (DefFracBits + 1)) + 10000) / 20000;
   endfunction

   function automatic chroma_type predict_chroma(input pixel_type px);
      chroma_type     res;
      longint unsigned r, g, b, sx, sy, sz, sum;
      r   = gamma_lut[px.red];
      g   = gamma_lut[px.green];
      b   = gamma_lut[px.blue];
      sx  = r * to_q16(CoefXR) + g * to_q16(CoefXG) + b * to_q16(CoefXB);
      sy  = r * to_q16(CoefYR) + g * to_q16(CoefYG) + b * to_q16(CoefYB);
      sz  = r * to_q16(CoefZR) + g * to_q16(CoefZG) + b * to_q16(CoefZB);
      sum = sx + sy + sz;
      if (sum == 0) begin
         // black pixel: zero stands in for the undefined ratio
         res.chroma_x = '0;
         res.chroma_y = '0;
      end else begin
         res.chroma_x = OutW'((sx * 65535) / sum);
         res.chroma_y = OutW'((sy * 65535) / sum);
      end
      return res;
   endfunction

   function automatic void add_pixel(input int r, input int g, input int b);
      pixel_type px;
      px.red   = ChanW'(r);
      px.green = ChanW'(g);
      px.blue  = ChanW'(b);
      pixel_q.push_back(px);
   endfunction

   // sender idle percentage by phase; the receiver cannot stall at all
   function automatic int sender_idle_pct(input int n);
      if (n < 300) return 22;
      if (n < 600) return 61;
      return 0;
   endfunction

   // driver: a transfer happens at an edge with start high and busy low
   always @(posedge clock) begin
      pixel_type px;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            px.red   = req_red;
            px.green = req_green;
            px.blue  = req_blue;
            chroma_q.push_back(predict_chroma(px));
            accepted_cnt++;
         end
         if (start && busy) begin
            // hold the current pixel until it is taken
         end else if (pixel_q.size() > 0 &&
                      $urandom_range(99) >= sender_idle_pct(accepted_cnt)) begin
            px = pixel_q.pop_front();
            start     <= 1'b1;
            req_red   <= px.red;
            req_green <= px.green;
            req_blue  <= px.blue;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: each strobed result is compared with the oldest prediction
   always @(posedge clock) begin
      chroma_type want;
      if (!reset && rsp_valid) begin
         if (chroma_q.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MaxReports)
               $display("unexpected result x=%0d y=%0d", rsp_chroma_x, rsp_chroma_y);
         end else begin
            want = chroma_q.pop_front();
            if (rsp_chroma_x !== want.chroma_x || rsp_chroma_y !== want.chroma_y) begin
               mismatch_cnt++;
               if (mismatch_cnt <= MaxReports)
                  $display("chroma differs: expected x=%0d y=%0d, got x=%0d y=%0d",
                           want.chroma_x, want.chroma_y, rsp_chroma_x, rsp_chroma_y);
            end
         end
      end
   end

   initial begin
      fill_gamma_lut();
      // directed: black, white, primaries, the linear/power segment boundary
      add_pixel(0, 0, 0);
      add_pixel(255, 255, 255);
      add_pixel(255, 0, 0);
      add_pixel(0, 255, 0);
      add_pixel(0, 0, 255);
      add_pixel(1, 0, 0);
      add_pixel(0, 1, 0);
      add_pixel(0, 0, 1);
      add_pixel(10, 10, 10);
      add_pixel(11, 11, 11);
      add_pixel(10, 11, 0);
      add_pixel(0, 10, 11);
      add_pixel(255, 255, 0);
      add_pixel(0, 255, 255);
      add_pixel(255, 0, 255);
      add_pixel(128, 128, 128);
      add_pixel(1, 1, 1);
      add_pixel(254, 1, 127);
      add_pixel(170, 85, 0);
      add_pixel(0, 0, 0);
      for (int i = 0; i < NumRandom; i++) begin
         case ($urandom_range(3))
            0:       add_pixel($urandom_range(12), $urandom_range(12), $urandom_range(12));
            1:       add_pixel($urandom_range(255), 0, $urandom_range(255));
            default: add_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255));
         endcase
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // drain: everything sent and every prediction compared
      while (pixel_q.size() != 0 || start || chroma_q.size() != 0)
         @(posedge clock);
      repeat (DrainWait) @(posedge clock);
      if (mismatch_cnt == 0 && chroma_q.size() == 0)
         $display("srgb_to_cie_xy: match");
      else
         $display("srgb_to_cie_xy: mismatch");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("srgb_to_cie_xy: mismatch");
      $finish;
   end

endmodule

[files.f]
design/srgbxy_pkg.sv
design/srgbxy_mix.sv
design/srgbxy_div_cell.sv
design/srgb_to_cie_xy.sv
sim/srgb_to_cie_xy_tb.sv
